// ===== hdl/run_length_mark_position_decoder_core_defines.svh =====
// Assertion macros for the run-length mark position decoder top level.
`ifndef RUN_LENGTH_MARK_POSITION_DECODER_CORE_DEFINES_SVH
`define RUN_LENGTH_MARK_POSITION_DECODER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only outside reset.
`define RLMPD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define RLMPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RLMPD_ASSERT(lbl, clk, rst, prop, msg)
`define RLMPD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/rlmpd_pkg.sv =====
// Shared types, character constants and the control program of the decoder.
package rlmpd_pkg;

  localparam logic [6:0] CH_ESCAPE     = 7'h23;
  localparam logic [6:0] CH_RETURN     = 7'h0D;
  localparam logic [6:0] CH_COUNT_BASE = 7'h40;
  localparam logic [7:0] CH_VALUE_BASE = 8'h30;
  localparam logic [5:0] WIDTH_RESET   = 6'd48;
  localparam logic [7:0] ROW_MAX       = 8'hFF;

  localparam logic [1:0] PHASE_PLAIN = 2'd0;
  localparam logic [1:0] PHASE_COUNT = 2'd1;
  localparam logic [1:0] PHASE_VALUE = 2'd2;

  typedef logic [3:0] upc_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_FETCH,
    OP_END_SHEET,
    OP_SET_COUNT,
    OP_LOAD_RUN,
    OP_LOAD_ONE,
    OP_EMIT,
    OP_SET_ESC
  } op_t;

  typedef enum logic [2:0] {
    CND_ALWAYS,
    CND_IN_TAKE,
    CND_IS_CR,
    CND_PH_COUNT,
    CND_PH_VALUE,
    CND_IS_ESC,
    CND_RUN_ZERO,
    CND_EMIT_DONE
  } cond_t;

  // When the condition is false the step either falls through or, with stay set, repeats.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
    logic  stay;
  } uword_t;

  typedef struct packed {
    logic in_take;
    logic is_cr;
    logic ph_count;
    logic ph_value;
    logic is_esc;
    logic run_zero;
    logic emit_done;
  } dp_status_t;

  localparam upc_t A_FETCH     = 4'd0;
  localparam upc_t A_TEST_CR   = 4'd1;
  localparam upc_t A_TEST_CNT  = 4'd2;
  localparam upc_t A_TEST_VAL  = 4'd3;
  localparam upc_t A_TEST_ESC  = 4'd4;
  localparam upc_t A_LOAD_ONE  = 4'd5;
  localparam upc_t A_END_SHEET = 4'd6;
  localparam upc_t A_SET_COUNT = 4'd7;
  localparam upc_t A_LOAD_RUN  = 4'd8;
  localparam upc_t A_EMIT      = 4'd9;
  localparam upc_t A_SET_ESC   = 4'd10;

  function automatic uword_t ucode_rom(input upc_t addr);
    uword_t w;
    unique case (addr)
      A_FETCH:     w = '{op: OP_FETCH,     cond: CND_IN_TAKE,   target: A_TEST_CR,   stay: 1'b1};
      A_TEST_CR:   w = '{op: OP_NONE,      cond: CND_IS_CR,     target: A_END_SHEET, stay: 1'b0};
      A_TEST_CNT:  w = '{op: OP_NONE,      cond: CND_PH_COUNT,  target: A_SET_COUNT, stay: 1'b0};
      A_TEST_VAL:  w = '{op: OP_NONE,      cond: CND_PH_VALUE,  target: A_LOAD_RUN,  stay: 1'b0};
      A_TEST_ESC:  w = '{op: OP_NONE,      cond: CND_IS_ESC,    target: A_SET_ESC,   stay: 1'b0};
      A_LOAD_ONE:  w = '{op: OP_LOAD_ONE,  cond: CND_ALWAYS,    target: A_EMIT,      stay: 1'b0};
      A_END_SHEET: w = '{op: OP_END_SHEET, cond: CND_ALWAYS,    target: A_FETCH,     stay: 1'b0};
      A_SET_COUNT: w = '{op: OP_SET_COUNT, cond: CND_ALWAYS,    target: A_FETCH,     stay: 1'b0};
      A_LOAD_RUN:  w = '{op: OP_LOAD_RUN,  cond: CND_RUN_ZERO,  target: A_FETCH,     stay: 1'b0};
      A_EMIT:      w = '{op: OP_EMIT,      cond: CND_EMIT_DONE, target: A_FETCH,     stay: 1'b1};
      A_SET_ESC:   w = '{op: OP_SET_ESC,   cond: CND_ALWAYS,    target: A_FETCH,     stay: 1'b0};
      default:     w = '{op: OP_NONE,      cond: CND_ALWAYS,    target: A_FETCH,     stay: 1'b0};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/rlmpd_sequencer.sv =====
// Step counter, control store lookup and conditional branch logic.
module rlmpd_sequencer
  import rlmpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dp_status_t status,
  output uword_t     cw,
  output upc_t       upc
);

  upc_t upc_next;
  logic taken;

  assign cw = ucode_rom(upc);

  always_comb begin
    unique case (cw.cond)
      CND_ALWAYS:    taken = 1'b1;
      CND_IN_TAKE:   taken = status.in_take;
      CND_IS_CR:     taken = status.is_cr;
      CND_PH_COUNT:  taken = status.ph_count;
      CND_PH_VALUE:  taken = status.ph_value;
      CND_IS_ESC:    taken = status.is_esc;
      CND_RUN_ZERO:  taken = status.run_zero;
      CND_EMIT_DONE: taken = status.emit_done;
      default:       taken = 1'b1;
    endcase
  end

  always_comb begin
    if (taken) begin
      upc_next = cw.target;
    end else if (cw.stay) begin
      upc_next = upc;
    end else begin
      upc_next = upc + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= A_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// ===== hdl/rlmpd_datapath.sv =====
// Parser state, sheet position, run counter and the output word register.
module rlmpd_datapath
  import rlmpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  uword_t            cw,
  input  logic [5:0]        columns_per_row,
  input  logic [6:0]        rx_byte,
  input  logic              in_valid,
  output logic              in_ready,
  output logic [7:0]        mark_row,
  output logic [5:0]        mark_column,
  output logic signed [7:0] mark_value,
  output logic              last,
  output logic              out_valid,
  input  logic              out_ready,
  output dp_status_t        status
);

  logic [6:0] ch;
  logic [1:0] phase;
  logic [5:0] run_count;
  logic [5:0] remaining;
  logic [7:0] row;
  logic [5:0] col;

  logic       slot_free;
  logic       emit;
  logic [5:0] col_inc;
  logic       wrap;
  logic [6:0] count_diff;

  // No word is taken while reset holds the sequencer.
  assign in_ready   = (cw.op == OP_FETCH) && !rst;
  assign slot_free  = !out_valid || out_ready;
  assign emit       = (cw.op == OP_EMIT) && slot_free;
  assign col_inc    = col + 6'd1;
  // A width of zero makes every advance wrap, as does a column past a lowered width.
  assign wrap       = (col_inc >= columns_per_row) || (col_inc == 6'd0);
  assign count_diff = ch - CH_COUNT_BASE;

  always_comb begin
    status.in_take   = in_valid && in_ready;
    status.is_cr     = (ch == CH_RETURN);
    status.ph_count  = (phase == PHASE_COUNT);
    status.ph_value  = (phase == PHASE_VALUE);
    status.is_esc    = (ch == CH_ESCAPE);
    status.run_zero  = (run_count == 6'd0);
    status.emit_done = slot_free && (remaining == 6'd1);
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch <= rx_byte;
    end
    if (emit) begin
      mark_row    <= row;
      mark_column <= col;
      mark_value  <= signed'({1'b0, ch} - CH_VALUE_BASE);
      last        <= (remaining == 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PHASE_PLAIN;
      run_count <= 6'd0;
      remaining <= 6'd0;
      row       <= 8'd0;
      col       <= 6'd0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (cw.op)
        OP_END_SHEET: begin
          phase     <= PHASE_PLAIN;
          run_count <= 6'd0;
          row       <= 8'd0;
          col       <= 6'd0;
        end
        OP_SET_COUNT: begin
          run_count <= (ch > CH_COUNT_BASE) ? count_diff[5:0] : 6'd0;
          phase     <= PHASE_VALUE;
        end
        OP_LOAD_RUN: begin
          remaining <= run_count;
          run_count <= 6'd0;
          phase     <= PHASE_PLAIN;
        end
        OP_LOAD_ONE: begin
          remaining <= 6'd1;
          phase     <= PHASE_PLAIN;
        end
        OP_SET_ESC: begin
          phase <= PHASE_COUNT;
        end
        OP_EMIT: begin
          if (slot_free) begin
            remaining <= remaining - 6'd1;
            if (wrap) begin
              col <= 6'd0;
              if (row != ROW_MAX) begin
                row <= row + 8'd1;
              end
            end else begin
              col <= col_inc;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/run_length_mark_position_decoder_core.sv =====
// Top level of the run-length mark position decoder with its register port.
//
//   Channel  Direction  Handshake            Word
//   input    in         in_valid/in_ready    rx_byte
//   output   out        out_valid/out_ready  mark_row, mark_column, mark_value, last
//   config   in         psel/penable/pready  columns_per_row at address 0
//
// A microcoded sequencer handles one byte at a time: a return ends the sheet,
// a count byte sets the run count, a value byte loads a run of N marks, an
// escape opens the count and any other byte loads a single mark. The emit
// step issues one mark per cycle while the output register drains; a stalled
// output holds that step. Synchronous reset clears the parser, the position
// and the output valid flag and sets columns_per_row to 48.
`include "run_length_mark_position_decoder_core_defines.svh"

module run_length_mark_position_decoder_core
  import rlmpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [6:0]        rx_byte,
  input  logic              in_valid,
  output logic              in_ready,
  output logic [7:0]        mark_row,
  output logic [5:0]        mark_column,
  output logic signed [7:0] mark_value,
  output logic              last,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [5:0] columns_per_row;
  uword_t     cw;
  upc_t       upc;
  dp_status_t status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {26'd0, columns_per_row} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_per_row <= WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      columns_per_row <= pwdata[5:0];
    end
  end

  rlmpd_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cw     (cw),
    .upc    (upc)
  );

  rlmpd_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cw              (cw),
    .columns_per_row (columns_per_row),
    .rx_byte         (rx_byte),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .mark_row        (mark_row),
    .mark_column     (mark_column),
    .mark_value      (mark_value),
    .last            (last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status)
  );

  `RLMPD_ASSERT(a_ready_at_fetch, clk, rst, in_ready |-> (upc == A_FETCH), "ready off fetch step")
  `RLMPD_ASSERT(a_take_leaves_fetch, clk, rst, (in_valid && in_ready) |=> !in_ready, "fetch not left")
  `RLMPD_ASSERT(a_column_range, clk, rst, out_valid |-> (mark_column != 6'd63), "column out of range")
  `RLMPD_ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !out_valid, "output valid after reset")

endmodule
